[rtl/core/assert_macros.svh]
// Assertion helper macros shared by the vertex cover RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define GVC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vertex cover check failed (same cycle)");

// Next-cycle implication, checked only while out of reset.
`define GVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vertex cover check failed (next cycle)");

`endif

[rtl/core/gvc_pkg.sv]
// Shared types and constants for the greedy vertex cover core.
// No dependencies; every other file of the block but assert_macros.svh refers to this package.
package gvc_pkg;

  // Fixed field widths of the channels and counters.
  localparam int VERTEX_W = 6;
  localparam int DEG_W = 7;
  localparam int CNT_W = 7;
  localparam int REM_W = 11;

  // Default graph size and reset value of the vertex count register.
  localparam int MAX_VERTICES_DEF = 64;
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_CHK,
    ST_LD_B,
    ST_SEL_RUN,
    ST_SEL_END,
    ST_DECIDE,
    ST_UPD_LOAD,
    ST_UPD_WALK,
    ST_UPD_TAIL
  } gvc_state_t;

  // Control strobes from the sequencer to the graph store.
  typedef struct packed {
    logic adj_we;
    logic deg_we;
    logic clear;
  } gvc_ctl_t;

endpackage

[rtl/core/gvc_if.sv]
// Valid/ready channel interfaces for edge beats and cover beats.
// Depends on gvc_pkg for the field widths.
interface gvc_edge_if;
  logic                          valid;
  logic                          ready;
  logic [gvc_pkg::VERTEX_W-1:0]  edge_from;
  logic [gvc_pkg::VERTEX_W-1:0]  edge_to;
  logic                          final_edge;

  modport source (output valid, output edge_from, output edge_to, output final_edge,
                  input ready);
  modport sink (input valid, input edge_from, input edge_to, input final_edge,
                output ready);
endinterface

interface gvc_cover_if;
  logic                          valid;
  logic                          ready;
  logic [gvc_pkg::VERTEX_W-1:0]  cover_vertex;
  logic                          last_in_cover;

  modport source (output valid, output cover_vertex, output last_in_cover, input ready);
  modport sink (input valid, input cover_vertex, input last_in_cover, output ready);
endinterface

[rtl/core/gvc_store.sv]
// Graph store: adjacency row memory and degree memory, each with per-entry valid bits.
// Depends on gvc_pkg for the control struct and the degree width.
module gvc_store #(
  parameter int MAX_VERTICES = gvc_pkg::MAX_VERTICES_DEF,
  localparam int IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gvc_pkg::gvc_ctl_t         ctl,
  input  logic [IDX_W-1:0]          adj_raddr,
  input  logic [IDX_W-1:0]          adj_waddr,
  input  logic [MAX_VERTICES-1:0]   adj_wdata,
  output logic [MAX_VERTICES-1:0]   adj_rdata,
  input  logic [IDX_W-1:0]          deg_raddr,
  input  logic [IDX_W-1:0]          deg_waddr,
  input  logic [gvc_pkg::DEG_W-1:0] deg_wdata,
  output logic [gvc_pkg::DEG_W-1:0] deg_rdata
);

  logic [MAX_VERTICES-1:0]   adj_mem [MAX_VERTICES];
  logic [gvc_pkg::DEG_W-1:0] deg_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]   adj_vld_r;
  logic [MAX_VERTICES-1:0]   deg_vld_r;
  logic [MAX_VERTICES-1:0]   adj_q_r;
  logic [gvc_pkg::DEG_W-1:0] deg_q_r;
  logic                      adj_vq_r;
  logic                      deg_vq_r;

  // Memory arrays: one write and one registered read per cycle on each.
  always_ff @(posedge clk) begin
    if (ctl.adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (ctl.deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    adj_q_r  <= adj_mem[adj_raddr];
    deg_q_r  <= deg_mem[deg_raddr];
    adj_vq_r <= adj_vld_r[adj_raddr];
    deg_vq_r <= deg_vld_r[deg_raddr];
  end

  // Valid bits: reset and the end-of-graph clear empty the whole store at once.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      adj_vld_r <= '0;
      deg_vld_r <= '0;
    end else begin
      if (ctl.adj_we) begin
        adj_vld_r[adj_waddr] <= 1'b1;
      end
      if (ctl.deg_we) begin
        deg_vld_r[deg_waddr] <= 1'b1;
      end
    end
  end

  // An entry never written since the last clear reads as zero.
  assign adj_rdata = adj_vq_r ? adj_q_r : '0;
  assign deg_rdata = deg_vq_r ? deg_q_r : '0;

endmodule

[rtl/core/greedy_max_degree_vertex_cover_core.sv]
// Greedy maximum-degree vertex cover. An edge beat passes ST_LD_CHK and ST_LD_B; a
// duplicate ends in ST_LD_CHK, an edge out of range or a self-loop in ST_IDLE. Cover:
// each chosen vertex costs a degree scan and decision plus a neighbour update, both on the
// single degree memory port; a closing scan follows, and a decision waits while the held
// cover beat cannot leave. Input is not ready from the final edge until the cover is done.
// Reset is synchronous, active low: the graph is cleared through valid bits, count is 64.
`include "assert_macros.svh"

module greedy_max_degree_vertex_cover_core #(
  parameter int MAX_VERTICES = gvc_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gvc_edge_if.sink                  in_edge,
  gvc_cover_if.source               out_cover,
  input  logic                      cfg_we,
  input  logic [gvc_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam logic [gvc_pkg::CNT_W-1:0] MAXV_C = gvc_pkg::CNT_W'(MAX_VERTICES);
  localparam logic [IDX_W-1:0] WALK_LAST = IDX_W'(MAX_VERTICES - 1);

  gvc_pkg::gvc_state_t state_r, state_nxt;
  gvc_pkg::gvc_ctl_t   ctl;

  logic [gvc_pkg::CNT_W-1:0]    cnt_r;
  logic [gvc_pkg::CNT_W-1:0]    n_eff;
  logic [gvc_pkg::CNT_W-1:0]    last_idx;
  logic [IDX_W-1:0]             a_r, b_r;
  logic                         fin_r;
  logic [gvc_pkg::REM_W-1:0]    rem_r;
  logic [MAX_VERTICES-1:0]      covered_r;
  logic [gvc_pkg::DEG_W-1:0]    best_r;
  logic                         found_r;
  logic [IDX_W-1:0]             pick_r;
  logic [IDX_W-1:0]             pend_r;
  logic                         have_pend_r;
  logic [IDX_W-1:0]             scan_r;
  logic [IDX_W-1:0]             walk_r;
  logic                         c_vld_r, c_unc_r;
  logic [IDX_W-1:0]             c_idx_r;
  logic                         p_vld_r, p_unc_r;
  logic [IDX_W-1:0]             p_idx_r;
  logic [MAX_VERTICES-1:0]      row_r;
  logic                         out_valid_r;
  logic [gvc_pkg::VERTEX_W-1:0] out_vertex_r;
  logic                         out_last_r;

  logic                         in_fire, edge_ok, dup, out_free, go_c, decide_hold;
  logic                         sel_start, clear_c, emit_c, take_c, better;
  logic [IDX_W-1:0]             adj_raddr, adj_waddr, deg_raddr, deg_waddr;
  logic [MAX_VERTICES-1:0]      adj_wdata, adj_rdata;
  logic [gvc_pkg::DEG_W-1:0]    deg_wdata, deg_rdata;

  gvc_store #(.MAX_VERTICES(MAX_VERTICES)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .adj_raddr (adj_raddr),
    .adj_waddr (adj_waddr),
    .adj_wdata (adj_wdata),
    .adj_rdata (adj_rdata),
    .deg_raddr (deg_raddr),
    .deg_waddr (deg_waddr),
    .deg_wdata (deg_wdata),
    .deg_rdata (deg_rdata)
  );

  // Effective vertex count: zero counts as one, oversize counts as the maximum.
  always_comb begin
    if (cnt_r == '0) begin
      n_eff = gvc_pkg::CNT_W'(1);
    end else if (cnt_r > MAXV_C) begin
      n_eff = MAXV_C;
    end else begin
      n_eff = cnt_r;
    end
  end
  assign last_idx = n_eff - gvc_pkg::CNT_W'(1);

  // Handshake and decision terms.
  assign in_edge.ready = (state_r == gvc_pkg::ST_IDLE);
  assign in_fire       = in_edge.valid && in_edge.ready;
  assign edge_ok       = (gvc_pkg::CNT_W'(in_edge.edge_from) < n_eff) &&
                         (gvc_pkg::CNT_W'(in_edge.edge_to) < n_eff) &&
                         (in_edge.edge_from != in_edge.edge_to);
  assign dup           = adj_rdata[b_r];
  assign out_free      = !out_valid_r || out_cover.ready;
  assign go_c          = found_r && (rem_r != '0);
  assign decide_hold   = have_pend_r && !out_free;
  assign better        = c_vld_r && c_unc_r && (deg_rdata > best_r);

  // Sequencer: next state, store strobes and memory addresses.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    adj_raddr = '0;
    adj_waddr = a_r;
    adj_wdata = adj_rdata | (MAX_VERTICES'(1) << b_r);
    deg_raddr = '0;
    deg_waddr = a_r;
    deg_wdata = deg_rdata + gvc_pkg::DEG_W'(1);
    clear_c   = 1'b0;
    emit_c    = 1'b0;
    take_c    = 1'b0;
    case (state_r)
      gvc_pkg::ST_IDLE: begin
        adj_raddr = in_edge.edge_from[IDX_W-1:0];
        deg_raddr = in_edge.edge_from[IDX_W-1:0];
        if (in_fire) begin
          if (edge_ok) begin
            state_nxt = gvc_pkg::ST_LD_CHK;
          end else if (in_edge.final_edge) begin
            state_nxt = gvc_pkg::ST_SEL_RUN;
          end
        end
      end
      gvc_pkg::ST_LD_CHK: begin
        adj_raddr = b_r;
        deg_raddr = b_r;
        if (dup) begin
          state_nxt = fin_r ? gvc_pkg::ST_SEL_RUN : gvc_pkg::ST_IDLE;
        end else begin
          ctl.adj_we = 1'b1;
          ctl.deg_we = 1'b1;
          state_nxt  = gvc_pkg::ST_LD_B;
        end
      end
      gvc_pkg::ST_LD_B: begin
        adj_waddr  = b_r;
        adj_wdata  = adj_rdata | (MAX_VERTICES'(1) << a_r);
        deg_waddr  = b_r;
        ctl.adj_we = 1'b1;
        ctl.deg_we = 1'b1;
        state_nxt  = fin_r ? gvc_pkg::ST_SEL_RUN : gvc_pkg::ST_IDLE;
      end
      gvc_pkg::ST_SEL_RUN: begin
        deg_raddr = scan_r;
        if (gvc_pkg::CNT_W'(scan_r) == last_idx) begin
          state_nxt = gvc_pkg::ST_SEL_END;
        end
      end
      gvc_pkg::ST_SEL_END: begin
        state_nxt = gvc_pkg::ST_DECIDE;
      end
      gvc_pkg::ST_DECIDE: begin
        adj_raddr = pick_r;
        if (!decide_hold) begin
          emit_c = have_pend_r;
          if (go_c) begin
            take_c    = 1'b1;
            state_nxt = gvc_pkg::ST_UPD_LOAD;
          end else begin
            clear_c   = 1'b1;
            ctl.clear = 1'b1;
            state_nxt = gvc_pkg::ST_IDLE;
          end
        end
      end
      gvc_pkg::ST_UPD_LOAD: begin
        state_nxt = gvc_pkg::ST_UPD_WALK;
      end
      gvc_pkg::ST_UPD_WALK: begin
        deg_raddr = walk_r;
        if (walk_r == WALK_LAST) begin
          state_nxt = gvc_pkg::ST_UPD_TAIL;
        end
      end
      gvc_pkg::ST_UPD_TAIL: begin
        state_nxt = gvc_pkg::ST_SEL_RUN;
      end
      default: begin
        state_nxt = gvc_pkg::ST_IDLE;
      end
    endcase
    // Neighbour update write-back: saturating decrement of the degree just read.
    if (p_vld_r) begin
      ctl.deg_we = 1'b1;
      deg_waddr  = p_idx_r;
      deg_wdata  = (deg_rdata == '0) ? '0 : deg_rdata - gvc_pkg::DEG_W'(1);
    end
  end

  assign sel_start = (state_nxt == gvc_pkg::ST_SEL_RUN) && (state_r != gvc_pkg::ST_SEL_RUN);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gvc_pkg::ST_IDLE;
      cnt_r       <= gvc_pkg::CNT_RESET;
      rem_r       <= '0;
      covered_r   <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      c_vld_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      c_vld_r <= (state_r == gvc_pkg::ST_SEL_RUN);
      p_vld_r <= (state_r == gvc_pkg::ST_UPD_WALK) && row_r[walk_r];
      // Remaining-edge count: one up per stored edge, one down per uncovered neighbour.
      if (clear_c) begin
        rem_r <= '0;
      end else if (state_r == gvc_pkg::ST_LD_B) begin
        rem_r <= rem_r + gvc_pkg::REM_W'(1);
      end else if (p_vld_r && p_unc_r && (rem_r != '0)) begin
        rem_r <= rem_r - gvc_pkg::REM_W'(1);
      end
      if (clear_c) begin
        covered_r <= '0;
      end else if (take_c) begin
        covered_r[pick_r] <= 1'b1;
      end
      if (take_c) begin
        have_pend_r <= 1'b1;
      end else if (clear_c) begin
        have_pend_r <= 1'b0;
      end
      if (sel_start) begin
        found_r <= 1'b0;
      end else if (better) begin
        found_r <= 1'b1;
      end
      if (emit_c) begin
        out_valid_r <= 1'b1;
      end else if (out_cover.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_r   <= in_edge.edge_from[IDX_W-1:0];
      b_r   <= in_edge.edge_to[IDX_W-1:0];
      fin_r <= in_edge.final_edge;
    end
    // Degree scan: the compare runs in the cycle after its read address.
    if (sel_start) begin
      scan_r <= '0;
      best_r <= '0;
    end else begin
      if (state_r == gvc_pkg::ST_SEL_RUN) begin
        scan_r <= scan_r + IDX_W'(1);
      end
      if (better) begin
        best_r <= deg_rdata;
        pick_r <= c_idx_r;
      end
    end
    c_idx_r <= scan_r;
    c_unc_r <= !covered_r[scan_r];
    // Neighbour walk over the chosen vertex's adjacency row.
    if (state_r == gvc_pkg::ST_UPD_LOAD) begin
      row_r  <= adj_rdata;
      walk_r <= '0;
    end else if (state_r == gvc_pkg::ST_UPD_WALK) begin
      walk_r <= walk_r + IDX_W'(1);
    end
    p_idx_r <= walk_r;
    p_unc_r <= !covered_r[walk_r];
    if (take_c) begin
      pend_r <= pick_r;
    end
    // A held vertex is sent as last when no further pick follows it.
    if (emit_c) begin
      out_vertex_r <= gvc_pkg::VERTEX_W'(pend_r);
      out_last_r   <= !go_c;
    end
  end

  assign out_cover.valid         = out_valid_r;
  assign out_cover.cover_vertex  = out_vertex_r;
  assign out_cover.last_in_cover = out_last_r;

  // Checks on the cover sequencer.
  `GVC_ASSERT_IMPLIES(a_pick_uncovered, take_c, !covered_r[pick_r] && (best_r != '0))
  `GVC_ASSERT_NEXT(a_clear_empties, clear_c, (rem_r == '0) && (covered_r == '0))
  `GVC_ASSERT_IMPLIES(a_idle_no_pending, in_edge.ready, !have_pend_r)

endmodule

[tb/sv/greedy_max_degree_vertex_cover_checker.sv]
// Checker for the greedy vertex cover core: watches the edge, cover and register ports.
// It predicts the cover beats of every graph and compares them as they leave the block.
// Depends on gvc_pkg and the channel interfaces in gvc_if.sv.
module greedy_max_degree_vertex_cover_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  gvc_edge_if                       edge_mon,
  gvc_cover_if                      cover_mon,
  input  logic                      cfg_we,
  input  logic [gvc_pkg::CNT_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        cover_beats
);

  localparam int NV = gvc_pkg::MAX_VERTICES_DEF;

  typedef struct packed {
    logic [gvc_pkg::VERTEX_W-1:0] vertex;
    logic                         last;
  } cover_beat_t;

  // Shadow copy of the graph store and the vertex count register.
  logic [NV-1:0]             adj_row [NV];
  logic [gvc_pkg::DEG_W-1:0] degree [NV];
  logic [NV-1:0]             covered;
  logic [gvc_pkg::REM_W-1:0] edges_left;
  logic [gvc_pkg::CNT_W-1:0] vcount;
  cover_beat_t               cover_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : predict
    int n;
    int a;
    int b;
    int best;
    int pick;
    int picked;
    bit found;
    cover_beat_t want;
    cover_beat_t beat;
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) begin
        adj_row[i] = '0;
        degree[i] = '0;
      end
      covered = '0;
      edges_left = '0;
      vcount = gvc_pkg::CNT_RESET;
      cover_q.delete();
    end else begin
      // Compare a cover beat against the oldest prediction.
      if (cover_mon.valid && cover_mon.ready) begin
        cover_beats++;
        if (cover_q.size() == 0) begin
          report_mismatch("cover beat with nothing expected", cover_mon.cover_vertex, -1);
        end else begin
          want = cover_q.pop_front();
          if (cover_mon.cover_vertex !== want.vertex)
            report_mismatch("cover_vertex", cover_mon.cover_vertex, want.vertex);
          if (cover_mon.last_in_cover !== want.last)
            report_mismatch("last_in_cover", cover_mon.last_in_cover, want.last);
        end
      end

      if (edge_mon.valid && edge_mon.ready) begin
        n = (vcount == 0) ? 1 : (vcount > NV) ? NV : int'(vcount);
        a = edge_mon.edge_from;
        b = edge_mon.edge_to;

        // Store the edge unless it is out of range, a self-loop or already present.
        if (a < n && b < n && a != b && !adj_row[a][b]) begin
          adj_row[a][b] = 1'b1;
          adj_row[b][a] = 1'b1;
          degree[a] = degree[a] + 1'b1;
          degree[b] = degree[b] + 1'b1;
          edges_left = edges_left + 1'b1;
        end

        // The final edge runs the greedy selection and then empties the graph.
        if (edge_mon.final_edge) begin
          picked = 0;
          while (edges_left != 0 && picked < NV) begin
            best = 0;
            pick = 0;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
              if (!covered[i] && int'(degree[i]) > best) begin
                best = degree[i];
                pick = i;
                found = 1'b1;
              end
            end
            if (!found)
              break;
            covered[pick] = 1'b1;
            for (int u = 0; u < NV; u++) begin
              if (adj_row[pick][u]) begin
                if (!covered[u] && edges_left != 0)
                  edges_left = edges_left - 1'b1;
                if (degree[u] != 0)
                  degree[u] = degree[u] - 1'b1;
              end
            end
            beat.vertex = pick[gvc_pkg::VERTEX_W-1:0];
            beat.last   = 1'b0;
            cover_q.insert(cover_q.size(), beat);
            picked++;
          end
          if (picked > 0)
            cover_q[cover_q.size()-1].last = 1'b1;
          for (int i = 0; i < NV; i++) begin
            adj_row[i] = '0;
            degree[i] = '0;
          end
          covered = '0;
          edges_left = '0;
        end
      end

      // A register write takes effect after any edge beat of the same clock edge.
      if (cfg_we)
        vcount = cfg_wdata;
    end
    pending <= cover_q.size();
  end

endmodule

[tb/sv/greedy_max_degree_vertex_cover_core_test.sv]
// Top of the greedy vertex cover regression: clock, reset, edge and register stimulus.
// Instantiates the core and its checker; depends on gvc_pkg, gvc_if.sv and the checker.
module greedy_max_degree_vertex_cover_core_test;

  localparam int RANDOM_ITEMS   = 350;
  localparam int IDLE_GUARD     = gvc_pkg::MAX_VERTICES_DEF + 16;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [gvc_pkg::CNT_W-1:0] cfg_wdata;

  gvc_edge_if  edge_ch ();
  gvc_cover_if cover_ch ();

  int fail_count;
  int pending;
  int cover_beats;

  // Stimulus bookkeeping.
  logic [gvc_pkg::CNT_W-1:0]    cur_count;
  logic [gvc_pkg::VERTEX_W-1:0] prev_from;
  logic [gvc_pkg::VERTEX_W-1:0] prev_to;
  bit                           tx_burst;
  int                           edge_beats;
  int                           graphs;
  int                           count_writes;
  int                           useful_edges;
  int                           idle_cycles = 0;

  greedy_max_degree_vertex_cover_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_edge   (edge_ch),
    .out_cover (cover_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  greedy_max_degree_vertex_cover_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .edge_mon    (edge_ch),
    .cover_mon   (cover_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .cover_beats (cover_beats)
  );

  always #5 clk = ~clk;

  function automatic int eff_n(input logic [gvc_pkg::CNT_W-1:0] c);
    return (c == 0) ? 1 :
           (c > gvc_pkg::MAX_VERTICES_DEF) ? gvc_pkg::MAX_VERTICES_DEF : int'(c);
  endfunction

  // Offer one edge beat after a random gap, none in a burst, and hold it until it is taken.
  task automatic send_edge(input int a, input int b, input bit fin);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      edge_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edge_ch.valid      <= 1'b1;
    edge_ch.edge_from  <= a[gvc_pkg::VERTEX_W-1:0];
    edge_ch.edge_to    <= b[gvc_pkg::VERTEX_W-1:0];
    edge_ch.final_edge <= fin;
    do @(posedge clk); while (!edge_ch.ready);
    edge_beats++;
    if (fin)
      graphs++;
    if (a < eff_n(cur_count) && b < eff_n(cur_count) && a != b)
      useful_edges++;
    prev_from = a[gvc_pkg::VERTEX_W-1:0];
    prev_to   = b[gvc_pkg::VERTEX_W-1:0];
  endtask

  // Change the vertex count only once the block has drained and gone quiet.
  task automatic write_vertex_count(input int value);
    edge_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[gvc_pkg::CNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_count = value[gvc_pkg::CNT_W-1:0];
    count_writes++;
  endtask

  // A random graph: mostly edges inside the active range, some noise, repeats and self-loops.
  task automatic send_random_graph(input int n_edges);
    int n;
    int r;
    int a;
    int b;
    for (int k = 0; k < n_edges; k++) begin
      if (k == n_edges / 2 && k > 0 && $urandom_range(0, 99) < 8)
        write_vertex_count($urandom_range(1, gvc_pkg::MAX_VERTICES_DEF));
      n = eff_n(cur_count);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
      end else if (r < 90) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end else if (r < 95) begin
        a = prev_to;
        b = prev_from;
      end else begin
        a = $urandom_range(0, n - 1);
        b = a;
      end
      send_edge(a, b, k == n_edges - 1);
    end
  endtask

  // Receiver: random stalls per beat, stretches with no stall, and one long hold-off
  // in the middle of a cover so that the core backs up and stalls its input.
  initial begin : receiver
    int gap;
    int got;
    bit held;
    got = 0;
    held = 1'b0;
    cover_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && got >= 10 && !cover_ch.last_in_cover) begin
        gap = LONG_HOLD;
        held = 1'b1;
      end else if (got % 32 >= 24) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
        cover_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cover_ch.ready <= 1'b1;
      do @(posedge clk); while (!cover_ch.valid);
      got++;
    end
  end

  // Watchdog on cycles in which no beat moves and no register is written.
  always @(posedge clk) begin
    if ((edge_ch.valid && edge_ch.ready) || (cover_ch.valid && cover_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles.", idle_cycles);
      $display("greedy_max_degree_vertex_cover_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    edge_ch.valid      <= 1'b0;
    edge_ch.edge_from  <= '0;
    edge_ch.edge_to    <= '0;
    edge_ch.final_edge <= 1'b0;
    cur_count          = gvc_pkg::CNT_RESET;
    prev_from          = '0;
    prev_to            = '0;
    tx_burst           = 1'b0;
    edge_beats         = 0;
    graphs             = 0;
    count_writes       = 0;
    useful_edges       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset count: extreme indices, reversed and repeated duplicates, a self-loop.
    send_edge(0, 63, 1'b0);
    send_edge(63, 0, 1'b0);
    send_edge(0, 63, 1'b0);
    send_edge(5, 5, 1'b0);
    send_edge(63, 62, 1'b0);
    send_edge(0, 1, 1'b1);
    // Empty graph of one final self-loop, then a graph whose final mark rides on a duplicate.
    send_edge(7, 7, 1'b1);
    send_edge(2, 3, 1'b0);
    send_edge(3, 2, 1'b1);

    // A count of zero acts as one vertex, so every edge is out of range.
    write_vertex_count(0);
    send_edge(0, 1, 1'b1);
    // The largest count clamps to the full size; an all-tie triangle picks the lowest.
    write_vertex_count((1 << gvc_pkg::CNT_W) - 1);
    send_edge(63, 62, 1'b0);
    send_edge(62, 61, 1'b0);
    send_edge(61, 63, 1'b1);
    // Two vertices: an endpoint beyond the count is dropped.
    write_vertex_count(2);
    send_edge(0, 1, 1'b0);
    send_edge(1, 2, 1'b0);
    send_edge(0, 1, 1'b1);
    // Load with the full count, then lower it before the final edge.
    write_vertex_count(gvc_pkg::MAX_VERTICES_DEF);
    send_edge(40, 41, 1'b0);
    send_edge(3, 4, 1'b0);
    send_edge(41, 42, 1'b0);
    write_vertex_count(8);
    send_edge(4, 5, 1'b1);

    // Random graphs under a spread of vertex counts.
    while (edge_beats < RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 3) begin
        r = $urandom_range(0, 99);
        if (r < 65)
          write_vertex_count($urandom_range(2, 12));
        else if (r < 75)
          write_vertex_count(gvc_pkg::MAX_VERTICES_DEF);
        else if (r < 88)
          write_vertex_count($urandom_range(13, 63));
        else if (r < 94)
          write_vertex_count($urandom_range(0, 1));
        else
          write_vertex_count($urandom_range(gvc_pkg::MAX_VERTICES_DEF + 1,
                                            (1 << gvc_pkg::CNT_W) - 1));
      end
      if ($urandom_range(0, 19) == 0)
        send_random_graph(30);
      else
        send_random_graph($urandom_range(1, 10));
    end

    // Drain every expected beat, then give the core time to show anything extra.
    edge_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);

    $display("Sent %0d edge beats (%0d of them in range and not self-loops) in %0d graphs",
             edge_beats, useful_edges, graphs);
    $display("with %0d vertex-count writes; checked %0d cover beats, %0d mismatches.",
             count_writes, cover_beats, fail_count);
    if (fail_count == 0)
      $display("greedy_max_degree_vertex_cover_core regression: pass");
    else
      $display("greedy_max_degree_vertex_cover_core regression: fail");
    $finish;
  end

endmodule
